// ----- hw/rtl/tlba_pkg.sv -----
// Shared types, codes and helpers for the two-level bitmap slot allocator.
`default_nettype none

package tlba_pkg;

	localparam int SLOT_W = 10;

	typedef enum logic {
		ACT_ALLOC   = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	typedef enum logic {
		STAT_DONE = 1'b0,
		STAT_FULL = 1'b1
	} status_t;

	// classification made by the front end
	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_DROP    = 2'd2
	} op_kind_t;

	typedef enum logic [2:0] {
		BS_INIT = 3'd0,
		BS_IDLE = 3'd1,
		BS_SUM  = 3'd2,
		BS_LEAF = 3'd3,
		BS_REL  = 3'd4
	} back_state_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [SLOT_W-1:0]   slot_index;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} back_ctl_t;

	// lowest set bit of a byte; 0 for an empty byte
	function automatic logic [2:0] lowest_bit8(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) r = 3'(i);
		end
		return r;
	endfunction

	// bit b set when base + b lies below limit
	function automatic logic [7:0] ones_below(input int unsigned base,
		input int unsigned limit);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = ((base + 32'(i)) < limit);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tlba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tlba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tlba_front.sv -----
// Front end: request intake, classification and a two-entry queue.
`default_nettype none

module tlba_front import tlba_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic              action,
	input  wire logic [SLOT_W-1:0] slot_index,
	input  wire back_ctl_t         back_ctl,
	output q_head_t                q_head
);

	q_entry_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	q_entry_t   new_entry;
	logic       push;

	always_comb begin
		new_entry.slot_index = slot_index;
		if (action == ACT_ALLOC) begin
			new_entry.kind = OP_ALLOC;
		end else if (32'(slot_index) < SLOTS) begin
			new_entry.kind = OP_RELEASE;
		end else begin
			new_entry.kind = OP_DROP;
		end
	end

	assign req_ready    = (count_q != 2'd2) && !back_ctl.busy;
	assign push         = req_valid && req_ready;
	assign q_head.valid = (count_q != 2'd0);
	assign q_head.entry = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= new_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (back_ctl.pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, back_ctl.pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tlba_back.sv -----
// Back end: bitmap RAMs, search/update sequencer and result register.
`default_nettype none

module tlba_back import tlba_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire q_head_t            q_head,
	output back_ctl_t               back_ctl,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output logic [SLOT_W-1:0]       granted_slot,
	output logic                    status,
	output logic                    space_left
);

	localparam int LEAF_BYTES = (SLOTS + 7) / 8;
	localparam int SUM_BYTES  = (SLOTS + 63) / 64;
	localparam int LEAF_AW    = (LEAF_BYTES > 1) ? $clog2(LEAF_BYTES) : 1;
	localparam int SUM_AW     = (SUM_BYTES > 1) ? $clog2(SUM_BYTES) : 1;

	back_state_t state_q, state_d;

	logic [LEAF_AW-1:0]   init_cnt_q;
	logic [SUM_BYTES-1:0] top_q, top_d;
	logic [SUM_AW-1:0]    k_q;
	logic [LEAF_AW-1:0]   leaf_q;
	logic [2:0]           sj_q;
	logic [2:0]           bit_q;
	logic [7:0]           sum_byte_q;

	logic [SUM_AW-1:0]  sum_raddr, sum_waddr, k_first;
	logic [LEAF_AW-1:0] leaf_raddr, leaf_waddr, alloc_leaf;
	logic [7:0]         sum_rdata, sum_wdata, leaf_rdata, leaf_wdata;
	logic               sum_we, leaf_we;
	logic [2:0]         low_sum, low_leaf;
	logic [7:0]         leaf_new, sum_new;
	logic               out_free, init_last;
	logic               ld_alloc, ld_rel, cap_sum, res_load;
	logic [SLOT_W-1:0]  res_slot;
	logic               res_status, res_space;

	tlba_ram #(.WIDTH(8), .DEPTH(LEAF_BYTES)) u_leaf_ram (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (leaf_waddr),
		.wdata (leaf_wdata),
		.raddr (leaf_raddr),
		.rdata (leaf_rdata)
	);

	tlba_ram #(.WIDTH(8), .DEPTH(SUM_BYTES)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	assign out_free   = !rsp_valid || rsp_ready;
	assign init_last  = (init_cnt_q == LEAF_AW'(LEAF_BYTES - 1));
	assign low_sum    = lowest_bit8(sum_rdata);
	assign low_leaf   = lowest_bit8(leaf_rdata);
	assign alloc_leaf = LEAF_AW'({k_q, low_sum});
	assign leaf_new   = leaf_rdata & ~(8'd1 << low_leaf);
	assign sum_new    = sum_byte_q & ~(8'd1 << sj_q);

	// lowest summary byte holding a free leaf byte
	always_comb begin
		k_first = '0;
		for (int i = SUM_BYTES - 1; i >= 0; i--) begin
			if (top_q[i]) k_first = SUM_AW'(i);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BS_INIT: if (init_last) state_d = BS_IDLE;
			BS_IDLE: begin
				if (q_head.valid) begin
					if (q_head.entry.kind == OP_ALLOC && top_q != '0) state_d = BS_SUM;
					else if (q_head.entry.kind == OP_RELEASE) state_d = BS_REL;
				end
			end
			BS_SUM:  state_d = BS_LEAF;
			BS_LEAF: if (out_free) state_d = BS_IDLE;
			BS_REL:  if (out_free) state_d = BS_IDLE;
			default: state_d = BS_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		back_ctl.pop  = 1'b0;
		back_ctl.busy = (state_q == BS_INIT);
		sum_raddr  = k_q;
		leaf_raddr = leaf_q;
		sum_we     = 1'b0;
		sum_waddr  = k_q;
		sum_wdata  = sum_new;
		leaf_we    = 1'b0;
		leaf_waddr = leaf_q;
		leaf_wdata = leaf_new;
		top_d      = top_q;
		ld_alloc   = 1'b0;
		ld_rel     = 1'b0;
		cap_sum    = 1'b0;
		res_load   = 1'b0;
		res_slot   = '0;
		res_status = STAT_DONE;
		res_space  = |top_q;
		unique case (state_q)
			BS_INIT: begin
				leaf_we    = 1'b1;
				leaf_waddr = init_cnt_q;
				leaf_wdata = ones_below(32'(init_cnt_q) * 8, SLOTS);
				sum_we     = (32'(init_cnt_q) < SUM_BYTES);
				sum_waddr  = SUM_AW'(init_cnt_q);
				sum_wdata  = ones_below(32'(init_cnt_q) * 8, LEAF_BYTES);
			end
			BS_IDLE: begin
				if (q_head.valid) begin
					case (q_head.entry.kind)
						OP_ALLOC: begin
							if (top_q == '0) begin
								if (out_free) begin
									back_ctl.pop = 1'b1;
									res_load     = 1'b1;
									res_status   = STAT_FULL;
									res_space    = 1'b0;
								end
							end else begin
								back_ctl.pop = 1'b1;
								ld_alloc     = 1'b1;
								sum_raddr    = k_first;
							end
						end
						OP_RELEASE: begin
							back_ctl.pop = 1'b1;
							ld_rel       = 1'b1;
							leaf_raddr   = LEAF_AW'(q_head.entry.slot_index[SLOT_W-1:3]);
							sum_raddr    = SUM_AW'(q_head.entry.slot_index[SLOT_W-1:6]);
						end
						default: begin
							if (out_free) begin
								back_ctl.pop = 1'b1;
								res_load     = 1'b1;
							end
						end
					endcase
				end
			end
			BS_SUM: begin
				cap_sum    = 1'b1;
				leaf_raddr = alloc_leaf;
			end
			BS_LEAF: begin
				if (out_free) begin
					leaf_we = 1'b1;
					if (leaf_new == 8'd0) begin
						sum_we = 1'b1;
						if (sum_new == 8'd0) top_d[k_q] = 1'b0;
					end
					res_load  = 1'b1;
					res_slot  = SLOT_W'({leaf_q, low_leaf});
					res_space = |top_d;
				end
			end
			BS_REL: begin
				if (out_free) begin
					leaf_we     = 1'b1;
					leaf_wdata  = leaf_rdata | (8'd1 << bit_q);
					sum_we      = 1'b1;
					sum_wdata   = sum_rdata | (8'd1 << sj_q);
					top_d[k_q]  = 1'b1;
					res_load    = 1'b1;
					res_space   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_alloc) k_q <= k_first;
		if (ld_rel) begin
			k_q    <= SUM_AW'(q_head.entry.slot_index[SLOT_W-1:6]);
			leaf_q <= LEAF_AW'(q_head.entry.slot_index[SLOT_W-1:3]);
			sj_q   <= q_head.entry.slot_index[5:3];
			bit_q  <= q_head.entry.slot_index[2:0];
		end
		if (cap_sum) begin
			leaf_q     <= alloc_leaf;
			sj_q       <= low_sum;
			sum_byte_q <= sum_rdata;
		end
		if (res_load) begin
			granted_slot <= res_slot;
			status       <= res_status;
			space_left   <= res_space;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BS_INIT;
			init_cnt_q <= '0;
			top_q      <= '1;
			rsp_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BS_INIT) init_cnt_q <= init_cnt_q + 1'b1;
			top_q <= top_d;
			if (res_load) rsp_valid <= 1'b1;
			else if (rsp_ready) rsp_valid <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/two_level_bitmap_slot_allocator.sv -----
// Top level of the two-level bitmap slot allocator.
`default_nettype none

// Channel  Handshake              Payload
// req      req_valid/req_ready    action, slot_index
// rsp      rsp_valid/rsp_ready    granted_slot, status, space_left
//
// Allocate: summary RAM read, leaf RAM read, then write-back in the back end;
//   release: both RAMs read together, then written; a full allocate or an
//   out-of-range release loads its result from idle. The registered RAM read ports set the steps.
// Reset: a clearing pass writes one leaf byte (and the matching summary byte)
//   per cycle; req_ready stays low meanwhile.
// Stalls: a two-entry queue lets requests land while the back end works; a held
//   result in the output register blocks the next write-back or full/out-of-range result.
module two_level_bitmap_slot_allocator import tlba_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic              action,
	input  wire logic [SLOT_W-1:0] slot_index,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output logic [SLOT_W-1:0]      granted_slot,
	output logic                   status,
	output logic                   space_left
);

	q_head_t   q_head;
	back_ctl_t back_ctl;

	// intake and classification (allocate / release / out-of-range release)
	tlba_front #(.SLOTS(SLOTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.action     (action),
		.slot_index (slot_index),
		.back_ctl   (back_ctl),
		.q_head     (q_head)
	);

	// bitmap search and update, one transfer in flight at a time
	tlba_back #(.SLOTS(SLOTS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_head       (q_head),
		.back_ctl     (back_ctl),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.granted_slot (granted_slot),
		.status       (status),
		.space_left   (space_left)
	);

	// a full allocate grants nothing and leaves no space
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == STAT_FULL) |-> (granted_slot == '0 && !space_left))
		else $error("full result carries a slot or space");

	// no request taken during the clearing pass
	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		back_ctl.busy |-> !req_ready)
		else $error("request taken during clearing pass");

	// back end only pops a filled queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		back_ctl.pop |-> q_head.valid)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the two-level bitmap slot allocator.
`timescale 1ns / 100ps

module tb_top import tlba_pkg::*; ();

	localparam int SLOTS      = 1024;
	localparam int LEAF_BYTES = (SLOTS + 7) / 8;
	localparam int SUM_BYTES  = (SLOTS + 63) / 64;
	// watchdog limit, far above the reset clearing pass and any stall run
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		action_t           act;
		logic [SLOT_W-1:0] slot;
	} req_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] granted;
		status_t           stat;
		logic              space;
	} slot_outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	logic              action = 1'b0;
	logic [SLOT_W-1:0] slot_index = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	logic [SLOT_W-1:0] granted_slot;
	logic              status;
	logic              space_left;

	two_level_bitmap_slot_allocator #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.action      (action),
		.slot_index  (slot_index),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.granted_slot(granted_slot),
		.status      (status),
		.space_left  (space_left)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: our own copy of the two bitmaps, updated per accepted
	// request transfer, in the same order the block sees them.
	// ------------------------------------------------------------------
	logic [7:0] leaf_map [LEAF_BYTES];
	logic [7:0] sum_map  [SUM_BYTES];

	function automatic int first_set(logic [7:0] v);
		for (int b = 0; b < 8; b++) begin
			if (v[b]) return b;
		end
		return 0;
	endfunction

	function automatic slot_outcome_t allocator_step(action_t act, logic [SLOT_W-1:0] idx);
		slot_outcome_t r;
		int            grp;
		int            leaf;
		int            bitn;
		bit            hit;
		r.granted = '0;
		r.stat    = STAT_DONE;
		r.space   = 1'b0;
		hit       = 1'b0;
		if (act == ACT_ALLOC) begin
			// lowest summary bit picks the leaf byte, lowest leaf bit picks the slot
			for (grp = 0; grp < SUM_BYTES && !hit; grp++) begin
				if (sum_map[grp] != 8'h00) begin
					leaf = grp * 8 + first_set(sum_map[grp]);
					bitn = first_set(leaf_map[leaf]);
					leaf_map[leaf][bitn] = 1'b0;
					if (leaf_map[leaf] == 8'h00) sum_map[grp][leaf % 8] = 1'b0;
					r.granted = SLOT_W'(leaf * 8 + bitn);
					hit = 1'b1;
				end
			end
			if (!hit) r.stat = STAT_FULL;
		end else if (int'(idx) < SLOTS) begin
			// release sets both bits; releasing a free slot changes nothing
			leaf = int'(idx) / 8;
			leaf_map[leaf][idx % 8] = 1'b1;
			sum_map[leaf / 8][leaf % 8] = 1'b1;
		end
		for (grp = 0; grp < SUM_BYTES; grp++) begin
			if (sum_map[grp] != 8'h00) r.space = 1'b1;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus backlog and the generator's shadow of which slots are held.
	// The shadow only steers generation (e.g. release what is held); the
	// checking relies on the predictor above.
	// ------------------------------------------------------------------
	req_item_t     req_backlog [$];
	slot_outcome_t expected_grants [$];
	bit            slot_taken [SLOTS];
	int            held_slots [$];
	int            taken_count = 0;
	int            queued = 0;
	int            mismatches = 0;

	task automatic enqueue_req(action_t a, logic [SLOT_W-1:0] s);
		req_item_t it;
		int        j;
		it.act  = a;
		it.slot = s;
		req_backlog.insert(req_backlog.size(), it);
		queued++;
		if (a == ACT_ALLOC) begin
			if (taken_count < SLOTS) begin
				for (j = 0; j < SLOTS; j++) begin
					if (!slot_taken[j]) break;
				end
				slot_taken[j] = 1'b1;
				held_slots.insert(held_slots.size(), j);
				taken_count++;
			end
		end else if (int'(s) < SLOTS && slot_taken[s]) begin
			slot_taken[s] = 1'b0;
			taken_count--;
			for (j = 0; j < held_slots.size(); j++) begin
				if (held_slots[j] == int'(s)) break;
			end
			held_slots.delete(j);
		end
	endtask

	// release a slot that is currently held, or any slot when none is
	task automatic release_held();
		int k;
		if (held_slots.size() == 0) begin
			enqueue_req(ACT_RELEASE, SLOT_W'($urandom_range(0, SLOTS - 1)));
		end else begin
			k = $urandom_range(0, held_slots.size() - 1);
			enqueue_req(ACT_RELEASE, SLOT_W'(held_slots[k]));
		end
	endtask

	// fill the page, then knock on it a few times while it is full
	task automatic fill_page(int extra);
		while (taken_count < SLOTS) enqueue_req(ACT_ALLOC, SLOT_W'($urandom));
		repeat (extra) enqueue_req(ACT_ALLOC, SLOT_W'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Idling: each side idles with a 15 in 100 chance, except in a calm window
	// (the last quarter of the cyc % 1024 range) where both sides run flat out.
	// ------------------------------------------------------------------
	int unsigned cyc = 0;
	int unsigned quiet = 0;
	logic        calm;

	assign calm = (cyc % 1024) >= 768;

	// Driver: presents the next backlog entry once the previous one has
	// transferred; valid and payload hold while ready is low.
	req_item_t nxt_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid  <= 1'b0;
			action     <= ACT_ALLOC;
			slot_index <= '0;
		end else begin
			if (req_valid && req_ready) begin
				expected_grants.insert(expected_grants.size(),
					allocator_step(action_t'(action), slot_index));
			end
			if (!req_valid || req_ready) begin
				if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
					nxt_req = req_backlog.pop_front();
					req_valid  <= 1'b1;
					action     <= nxt_req.act;
					slot_index <= nxt_req.slot;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every result transfer is checked against the oldest expectation.
	slot_outcome_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_grants.size() == 0) begin
					$display("%0t unexpected result: granted_slot %0d status %0b space_left %0b",
						$time, granted_slot, status, space_left);
					mismatches++;
				end else begin
					want = expected_grants.pop_front();
					if (granted_slot !== want.granted) begin
						$display("%0t granted_slot: expected %0d, got %0d",
							$time, want.granted, granted_slot);
						mismatches++;
					end
					if (status !== want.stat) begin
						$display("%0t status: expected %0b, got %0b", $time, want.stat, status);
						mismatches++;
					end
					if (space_left !== want.space) begin
						$display("%0t space_left: expected %0b, got %0b",
							$time, want.space, space_left);
						mismatches++;
					end
				end
			end
			rsp_ready <= calm || ($urandom_range(0, 99) >= 15);
		end
	end

	// Watchdog: ends the run if no transfer happens on either channel for too long.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet <= 0;
		end else if (quiet >= STUCK_LIMIT) begin
			$display("%0t no transfer for %0d cycles", $time, quiet);
			$display("** two_level_bitmap_slot_allocator: FAILED **");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------
	int burst;

	initial begin
		// predictor reset: every existing slot free, summary set per existing leaf byte
		foreach (leaf_map[k]) leaf_map[k] = 8'h00;
		foreach (sum_map[k]) sum_map[k] = 8'h00;
		for (int s = 0; s < SLOTS; s++) leaf_map[s / 8][s % 8] = 1'b1;
		for (int k = 0; k < LEAF_BYTES; k++) begin
			if (leaf_map[k] != 8'h00) sum_map[k / 8][k % 8] = 1'b1;
		end

		// Directed: empty out leaf byte 0 so its summary bit drops, slot_index
		// ignored on allocate, reuse of the lowest released slot, double release,
		// release of slots that were never taken.
		enqueue_req(ACT_ALLOC, '0);
		enqueue_req(ACT_ALLOC, '1);
		repeat (7) enqueue_req(ACT_ALLOC, SLOT_W'(10'h2AA));
		enqueue_req(ACT_RELEASE, SLOT_W'(3));
		enqueue_req(ACT_ALLOC, SLOT_W'(10'h155));
		enqueue_req(ACT_RELEASE, '1);
		enqueue_req(ACT_RELEASE, '1);
		enqueue_req(ACT_RELEASE, '0);
		enqueue_req(ACT_RELEASE, '0);
		enqueue_req(ACT_RELEASE, SLOT_W'(10'h2AA));
		enqueue_req(ACT_RELEASE, SLOT_W'(10'h155));
		enqueue_req(ACT_ALLOC, '0);
		enqueue_req(ACT_ALLOC, '0);

		// Random: episodes of drains, alloc bursts, mixed traffic and top-offs.
		while (queued < 850) begin
			burst = $urandom_range(1, 40);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat (burst) begin
						if ($urandom_range(0, 9) == 0)
							enqueue_req(ACT_RELEASE, SLOT_W'($urandom_range(0, SLOTS - 1)));
						else
							release_held();
					end
				end
				3, 4, 5: begin
					repeat (burst) enqueue_req(ACT_ALLOC, SLOT_W'($urandom));
				end
				9: begin
					if (taken_count > SLOTS - 64) fill_page($urandom_range(1, 3));
					else repeat (burst) enqueue_req(ACT_ALLOC, SLOT_W'($urandom));
				end
				default: begin
					repeat (burst) begin
						case ($urandom_range(0, 19))
							0, 1:          enqueue_req(ACT_RELEASE,
							                   SLOT_W'($urandom_range(0, SLOTS - 1)));
							2, 3, 4, 5, 6,
							7, 8:          release_held();
							default:       enqueue_req(ACT_ALLOC, SLOT_W'($urandom));
						endcase
					end
				end
			endcase
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every request to transfer and every result to be checked
		while (req_backlog.size() != 0 || req_valid || expected_grants.size() != 0)
			@(posedge clk);
		// leave room for any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("** two_level_bitmap_slot_allocator: PASSED **");
		else
			$display("** two_level_bitmap_slot_allocator: FAILED **");
		$finish;
	end

endmodule

// ----- two_level_bitmap_slot_allocator.f -----
hw/rtl/tlba_pkg.sv
hw/rtl/tlba_ram.sv
hw/rtl/tlba_front.sv
hw/rtl/tlba_back.sv
hw/rtl/two_level_bitmap_slot_allocator.sv
dv/tb_top.sv
